/* hdl/shader_source_tokenizer_defines.svh */
// Assertion macros shared by the RTL.
`ifndef SHADER_SOURCE_TOKENIZER_DEFINES_SVH
`define SHADER_SOURCE_TOKENIZER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a condition on every clock edge outside reset.
`define STS_ASSERT(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);
// Check that a trigger is followed in the next cycle by a consequence.
`define STS_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);
`else
`define STS_ASSERT(lbl, clk, rst_n, cond, msg)
`define STS_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg)
`endif

`endif

/* hdl/sts_pkg.sv */
`default_nettype none

package sts_pkg;

    localparam int OFFSET_W   = 24;
    localparam int LENGTH_W   = 24;
    localparam int LINE_W     = 20;
    localparam int KIND_W     = 3;
    localparam int CH_W       = 8;

    localparam int MAX_RES    = 3;
    localparam int RES_CNT_W  = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // Result kinds
    localparam logic [KIND_W-1:0] K_IDENT      = 3'd0;
    localparam logic [KIND_W-1:0] K_NUMBER     = 3'd1;
    localparam logic [KIND_W-1:0] K_PUNCT      = 3'd2;
    localparam logic [KIND_W-1:0] K_ANNOT      = 3'd3;
    localparam logic [KIND_W-1:0] K_DONE       = 3'd4;
    localparam logic [KIND_W-1:0] K_OPEN_BLOCK = 3'd5;
    localparam logic [KIND_W-1:0] K_OPEN_LIT   = 3'd6;

    // Character codes
    localparam logic [CH_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CH_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CH_W-1:0] CH_BANG   = 8'h21;
    localparam logic [CH_W-1:0] CH_GT     = 8'h3E;
    localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CH_W-1:0] CH_LOW_E  = 8'h65;
    localparam logic [CH_W-1:0] CH_UP_E   = 8'h45;
    localparam logic [CH_W-1:0] CH_USCORE = 8'h5F;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [OFFSET_W-1:0] offset;
        logic [LENGTH_W-1:0] length;
        logic [LINE_W-1:0]   line_number;
        logic                leads_line;
        logic                last_of_run;
    } res_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0]   count;
        res_t [MAX_RES-1:0]     item;
    } batch_t;

    function automatic logic is_letter(input logic [CH_W-1:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_USCORE;
    endfunction

    function automatic logic is_num(input logic [CH_W-1:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_word(input logic [CH_W-1:0] c);
        return is_letter(c) || is_num(c);
    endfunction

    function automatic logic [OFFSET_W-1:0] sat_off(input logic [31:0] v);
        return (v > 32'((64'd1 << OFFSET_W) - 64'd1)) ? '1 : v[OFFSET_W-1:0];
    endfunction

    function automatic logic [LINE_W-1:0] sat_line(input logic [31:0] v);
        return (v > 32'((64'd1 << LINE_W) - 64'd1)) ? '1 : v[LINE_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/sts_lexer.sv */
`default_nettype none

module sts_lexer #(
    parameter int POSITION_BITS = 24,
    parameter int LINE_BITS     = 20
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     accept,
    input  wire logic [sts_pkg::CH_W-1:0] ch,
    input  wire logic                     end_of_text,
    output sts_pkg::batch_t               batch
);

    localparam logic [3:0] M_IDLE       = 4'd0;
    localparam logic [3:0] M_SLASH      = 4'd1;
    localparam logic [3:0] M_DOT        = 4'd2;
    localparam logic [3:0] M_IDENT      = 4'd3;
    localparam logic [3:0] M_NUM        = 4'd4;
    localparam logic [3:0] M_NUM_E      = 4'd5;
    localparam logic [3:0] M_LINE       = 4'd6;
    localparam logic [3:0] M_BLOCK      = 4'd7;
    localparam logic [3:0] M_BLOCK_STAR = 4'd8;
    localparam logic [3:0] M_LIT        = 4'd9;
    localparam logic [3:0] M_LIT_ESC    = 4'd10;

    localparam logic [1:0] MK_START = 2'd0;
    localparam logic [1:0] MK_BANG  = 2'd1;
    localparam logic [1:0] MK_HIT   = 2'd2;
    localparam logic [1:0] MK_MISS  = 2'd3;

    logic [3:0]               mode_reg, mode_next;
    logic                     quote_reg, quote_next;
    logic [1:0]               marker_reg, marker_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [LINE_BITS-1:0]     line_reg, line_next;
    logic [LINE_BITS-1:0]     cline_reg, cline_next;
    logic                     has_tok_reg, has_tok_next;

    logic [POSITION_BITS-1:0] span_now;
    logic [POSITION_BITS-1:0] span_end;
    logic                     do_idle;
    logic                     failed;
    logic [sts_pkg::RES_CNT_W-1:0] cnt;
    sts_pkg::res_t [sts_pkg::MAX_RES-1:0] items;

    function automatic sts_pkg::res_t tok(
        input logic [sts_pkg::KIND_W-1:0] kind,
        input logic [POSITION_BITS-1:0]   off,
        input logic [POSITION_BITS-1:0]   len,
        input logic [LINE_BITS-1:0]       ln,
        input logic                       first
    );
        sts_pkg::res_t r;
        r.kind          = kind;
        r.offset        = sts_pkg::sat_off(32'(off));
        r.length        = sts_pkg::sat_off(32'(len));
        r.line_number   = sts_pkg::sat_line(32'(ln));
        r.leads_line    = first;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    always_comb begin
        mode_next    = mode_reg;
        quote_next   = quote_reg;
        marker_next  = marker_reg;
        start_next   = start_reg;
        line_next    = line_reg;
        cline_next   = cline_reg;
        has_tok_next = has_tok_reg;
        pos_next     = (pos_reg == '1) ? pos_reg : pos_reg + POSITION_BITS'(1);
        span_now     = (pos_reg >= start_reg) ? pos_reg - start_reg : '0;
        span_end     = '0;
        do_idle      = 1'b0;
        failed       = 1'b0;
        cnt          = '0;
        items        = '0;

        unique case (mode_reg) inside
            M_SLASH: begin
                if (ch == sts_pkg::CH_SLASH) begin
                    mode_next   = M_LINE;
                    marker_next = MK_START;
                end else if (ch == sts_pkg::CH_STAR) begin
                    mode_next  = M_BLOCK;
                    cline_next = line_reg;
                end else begin
                    items[cnt] = tok(sts_pkg::K_PUNCT, start_reg, POSITION_BITS'(1),
                                     line_next, !has_tok_next);
                    cnt = cnt + 2'd1;
                    has_tok_next = 1'b1;
                    do_idle = 1'b1;
                end
            end
            M_DOT: begin
                if (sts_pkg::is_num(ch)) begin
                    mode_next = M_NUM;
                end else begin
                    items[cnt] = tok(sts_pkg::K_PUNCT, start_reg, POSITION_BITS'(1),
                                     line_next, !has_tok_next);
                    cnt = cnt + 2'd1;
                    has_tok_next = 1'b1;
                    do_idle = 1'b1;
                end
            end
            M_IDENT: begin
                if (!sts_pkg::is_word(ch)) begin
                    items[cnt] = tok(sts_pkg::K_IDENT, start_reg, span_now,
                                     line_next, !has_tok_next);
                    cnt = cnt + 2'd1;
                    has_tok_next = 1'b1;
                    do_idle = 1'b1;
                end
            end
            M_NUM, M_NUM_E: begin
                if (mode_reg == M_NUM_E &&
                    (ch == sts_pkg::CH_PLUS || ch == sts_pkg::CH_MINUS)) begin
                    mode_next = M_NUM;
                end else if (sts_pkg::is_word(ch) || ch == sts_pkg::CH_DOT) begin
                    mode_next = (ch == sts_pkg::CH_LOW_E || ch == sts_pkg::CH_UP_E) ?
                                M_NUM_E : M_NUM;
                end else begin
                    items[cnt] = tok(sts_pkg::K_NUMBER, start_reg, span_now,
                                     line_next, !has_tok_next);
                    cnt = cnt + 2'd1;
                    has_tok_next = 1'b1;
                    do_idle = 1'b1;
                end
            end
            M_LINE: begin
                if (ch == sts_pkg::CH_NL) begin
                    if (marker_reg == MK_HIT) begin
                        items[cnt] = tok(sts_pkg::K_ANNOT, start_reg, span_now,
                                         line_next, !has_tok_next);
                        cnt = cnt + 2'd1;
                        has_tok_next = 1'b1;
                    end
                    do_idle = 1'b1;
                end else if (marker_reg == MK_START) begin
                    marker_next = (ch == sts_pkg::CH_BANG) ? MK_BANG : MK_MISS;
                end else if (marker_reg == MK_BANG) begin
                    marker_next = (ch == sts_pkg::CH_GT) ? MK_HIT : MK_MISS;
                end
            end
            M_BLOCK: begin
                if (ch == sts_pkg::CH_STAR) begin
                    mode_next = M_BLOCK_STAR;
                end else if (ch == sts_pkg::CH_NL) begin
                    line_next = (line_reg == '1) ? line_reg : line_reg + LINE_BITS'(1);
                end
            end
            M_BLOCK_STAR: begin
                if (ch == sts_pkg::CH_SLASH) begin
                    mode_next = M_IDLE;
                end else if (ch != sts_pkg::CH_STAR) begin
                    if (ch == sts_pkg::CH_NL) begin
                        line_next = (line_reg == '1) ? line_reg : line_reg + LINE_BITS'(1);
                    end
                    mode_next = M_BLOCK;
                end
            end
            M_LIT: begin
                if (ch == (quote_reg ? sts_pkg::CH_SQUOTE : sts_pkg::CH_DQUOTE)) begin
                    mode_next = M_IDLE;
                end else if (ch == sts_pkg::CH_BSLASH) begin
                    mode_next = M_LIT_ESC;
                end else if (ch == sts_pkg::CH_NL) begin
                    line_next = (line_reg == '1) ? line_reg : line_reg + LINE_BITS'(1);
                end
            end
            M_LIT_ESC: begin
                mode_next = M_LIT;
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        // Idle handling of the current byte, after any pending token is closed
        if (do_idle) begin
            mode_next = M_IDLE;
            if (ch == sts_pkg::CH_NL) begin
                line_next    = (line_reg == '1) ? line_reg : line_reg + LINE_BITS'(1);
                has_tok_next = 1'b0;
            end else if (ch == sts_pkg::CH_SPACE || ch == sts_pkg::CH_TAB ||
                         ch == sts_pkg::CH_CR) begin
                mode_next = M_IDLE;
            end else if (ch == sts_pkg::CH_SLASH) begin
                mode_next  = M_SLASH;
                start_next = pos_reg;
            end else if (ch == sts_pkg::CH_DQUOTE || ch == sts_pkg::CH_SQUOTE) begin
                mode_next  = M_LIT;
                quote_next = (ch == sts_pkg::CH_SQUOTE);
                cline_next = line_next;
                start_next = pos_reg;
            end else if (sts_pkg::is_letter(ch)) begin
                mode_next  = M_IDENT;
                start_next = pos_reg;
            end else if (sts_pkg::is_num(ch)) begin
                mode_next  = M_NUM;
                start_next = pos_reg;
            end else if (ch == sts_pkg::CH_DOT) begin
                mode_next  = M_DOT;
                start_next = pos_reg;
            end else begin
                items[cnt] = tok(sts_pkg::K_PUNCT, pos_reg, POSITION_BITS'(1),
                                 line_next, !has_tok_next);
                cnt = cnt + 2'd1;
                has_tok_next = 1'b1;
            end
        end

        // Flush at end of text, then report done or the open construct
        if (end_of_text) begin
            span_end = (pos_next >= start_next) ? pos_next - start_next : '0;
            unique case (mode_next) inside
                M_SLASH, M_DOT: begin
                    items[cnt] = tok(sts_pkg::K_PUNCT, start_next, POSITION_BITS'(1),
                                     line_next, !has_tok_next);
                    cnt = cnt + 2'd1;
                end
                M_IDENT: begin
                    items[cnt] = tok(sts_pkg::K_IDENT, start_next, span_end,
                                     line_next, !has_tok_next);
                    cnt = cnt + 2'd1;
                end
                M_NUM, M_NUM_E: begin
                    items[cnt] = tok(sts_pkg::K_NUMBER, start_next, span_end,
                                     line_next, !has_tok_next);
                    cnt = cnt + 2'd1;
                end
                M_LINE: begin
                    if (marker_next == MK_HIT) begin
                        items[cnt] = tok(sts_pkg::K_ANNOT, start_next, span_end,
                                         line_next, !has_tok_next);
                        cnt = cnt + 2'd1;
                    end
                end
                M_BLOCK, M_BLOCK_STAR: begin
                    items[cnt] = tok(sts_pkg::K_OPEN_BLOCK, start_next, '0, cline_next, 1'b0);
                    cnt = cnt + 2'd1;
                    failed = 1'b1;
                end
                M_LIT, M_LIT_ESC: begin
                    items[cnt] = tok(sts_pkg::K_OPEN_LIT, start_next, '0, cline_next, 1'b0);
                    cnt = cnt + 2'd1;
                    failed = 1'b1;
                end
                default: begin
                    failed = 1'b0;
                end
            endcase
            if (!failed) begin
                items[cnt] = tok(sts_pkg::K_DONE, pos_next, '0, line_next, 1'b0);
                cnt = cnt + 2'd1;
            end
            mode_next    = M_IDLE;
            quote_next   = 1'b0;
            marker_next  = MK_START;
            pos_next     = '0;
            start_next   = '0;
            line_next    = LINE_BITS'(1);
            cline_next   = LINE_BITS'(1);
            has_tok_next = 1'b0;
        end

        if (cnt != '0) begin
            items[cnt - 2'd1].last_of_run = 1'b1;
        end

        batch.count = cnt;
        batch.item  = items;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= M_IDLE;
            quote_reg   <= 1'b0;
            marker_reg  <= MK_START;
            pos_reg     <= '0;
            start_reg   <= '0;
            line_reg    <= LINE_BITS'(1);
            cline_reg   <= LINE_BITS'(1);
            has_tok_reg <= 1'b0;
        end else if (accept) begin
            mode_reg    <= mode_next;
            quote_reg   <= quote_next;
            marker_reg  <= marker_next;
            pos_reg     <= pos_next;
            start_reg   <= start_next;
            line_reg    <= line_next;
            cline_reg   <= cline_next;
            has_tok_reg <= has_tok_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/sts_result_fifo.sv */
`default_nettype none

module sts_result_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push_en,
    input  wire sts_pkg::batch_t push,
    output logic                 space_ok,
    output logic                 head_valid,
    output sts_pkg::res_t        head,
    input  wire logic            pop_ready
);

    sts_pkg::res_t entry_reg [sts_pkg::FIFO_DEPTH];

    logic [sts_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sts_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sts_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic [sts_pkg::RES_CNT_W-1:0]  push_n;
    logic                           pop;

    // Admit a byte only when a full run of results fits
    assign space_ok   = count_reg <= sts_pkg::FIFO_CNT_W'(sts_pkg::FIFO_DEPTH - sts_pkg::MAX_RES);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];
    assign pop        = head_valid && pop_ready;
    assign push_n     = push_en ? push.count : '0;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + sts_pkg::FIFO_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + sts_pkg::FIFO_PTR_W'(pop);
        count_next  = count_reg + sts_pkg::FIFO_CNT_W'(push_n) - sts_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < sts_pkg::MAX_RES; i++) begin
            if (i < int'(push_n)) begin
                entry_reg[wr_ptr_reg + sts_pkg::FIFO_PTR_W'(i)] <= push.item[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/shader_source_tokenizer.sv */
// Channel   Direction  Ports                                   Carries
// s_        in         s_tvalid s_tready s_tdata[7:0] s_tlast  source byte, end of text
// m_        out        m_tvalid m_tready m_tdata[71:0]         token fields
//                      m_tuser[2:0] m_tlast                    kind, last of run
//
// One source byte is taken per cycle while s_tready is high; its 0 to 3 results are
// written at that edge into a 4-entry result queue, whose head is offered on m_,
// and the queue drains one transfer per cycle while m_tready is high.
// s_tready is low while fewer than 3 queue entries are free.
// aresetn is synchronous, active low; it clears the scanner state and the queue.
// A stall on m_ halts input once fewer than 3 queue entries are free; results keep their order.
`default_nettype none

`include "shader_source_tokenizer_defines.svh"

module shader_source_tokenizer #(
    parameter int POSITION_BITS = 24,
    parameter int LINE_BITS     = 20
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tlast,   // end_of_text
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [23:0] offset, [47:24] length,
                                        // [67:48] line_number, [68] leads_line
    output logic [2:0]       m_tuser,   // [2:0] kind
    output logic             m_tlast    // last_of_run
);

    logic            accept;
    logic            space_ok;
    sts_pkg::batch_t batch;
    sts_pkg::res_t   head;
    logic            end_unmarked;
    logic            end_accept;
    logic            kind_ok;

    assign s_tready = space_ok;
    assign accept   = s_tvalid && space_ok;

    sts_lexer #(
        .POSITION_BITS (POSITION_BITS),
        .LINE_BITS     (LINE_BITS)
    ) u_lexer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .ch          (s_tdata),
        .end_of_text (s_tlast),
        .batch       (batch)
    );

    sts_result_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_en    (accept),
        .push       (batch),
        .space_ok   (space_ok),
        .head_valid (m_tvalid),
        .head       (head),
        .pop_ready  (m_tready)
    );

    assign m_tdata = {3'b000, head.leads_line, head.line_number, head.length, head.offset};
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_run;

    assign end_unmarked = m_tvalid && !m_tlast &&
                          (m_tuser == sts_pkg::K_DONE || m_tuser == sts_pkg::K_OPEN_BLOCK ||
                           m_tuser == sts_pkg::K_OPEN_LIT);
    assign end_accept   = accept && s_tlast;
    assign kind_ok      = m_tuser <= sts_pkg::K_OPEN_LIT;

    `STS_ASSERT(a_end_kind_last, aclk, aresetn, !end_unmarked, "end result without tlast")
    `STS_ASSERT_NEXT(a_end_result, aclk, aresetn, end_accept, m_tvalid, "no result after end")
    `STS_ASSERT(a_kind_in_range, aclk, aresetn, !m_tvalid || kind_ok, "kind out of range")

endmodule

`default_nettype wire
